FILE: rtl/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and constants for the ordered list store: item and result
// layouts, operation and status codes, and the command broadcast to cells.
// ----------------------------------------------------------------------------
package ols_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 5;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int DEF_DEPTH = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_READ_AT    = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_REMOVE     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic [LEN_W-1:0]         length;
    } t_result;

    // broadcast to every cell; at most one of the action bits is set
    typedef struct packed {
        logic                     push_front;
        logic                     push_back;
        logic                     pop_front;
        logic                     remove;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_cell_cmd;

endpackage

FILE: rtl/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded deque of signed words kept head-first in a chain of cells. Front
// pushes and pops shift the whole chain, removals shift from the first match on.
//
//   channel  ports                      transfer when
//   item     start, busy, i_item        start high and busy low at the edge
//   result   o_valid, o_result          o_valid high for one cycle
//
// One item per cycle; its result shows in the cycle after the transfer.
// busy is never raised: every operation completes in the cell chain as it
// is taken, the remove search rippling through the chain's match flags.
// Synchronous active-low reset empties the list; stored words are not cleared.
// The receiver cannot stall; o_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module ordered_list_store #(
    parameter int DEPTH = ols_pkg::DEF_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ols_pkg::t_item   i_item,
    output logic             o_valid,
    output ols_pkg::t_result o_result
);
    import ols_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    t_result                  r_result;
    t_result                  n_result;
    t_cell_cmd                w_cmd;
    logic                     w_accept;
    logic                     w_full;
    logic signed [DATA_W-1:0] w_rd_data;
    logic                     w_rd_any;

    logic signed [DATA_W-1:0] w_val   [DEPTH];
    logic                     w_rd_sel[DEPTH];
    logic                     w_found [DEPTH+1];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == FULL_CNT);
    assign w_found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_left;
            logic signed [DATA_W-1:0] w_right;
            if (g == 0) begin : g_head
                assign w_left = w_cmd.value;
            end else begin : g_mid
                assign w_left = w_val[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_val[g+1];
            end
            ols_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_count  (r_count),
                .i_left   (w_left),
                .i_right  (w_right),
                .i_found  (w_found[g]),
                .o_found  (w_found[g+1]),
                .o_rd_sel (w_rd_sel[g]),
                .o_val    (w_val[g])
            );
        end
    endgenerate

    // at most one cell selects, so an OR of the gated words is the read
    always_comb begin
        w_rd_data = '0;
        w_rd_any  = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_data = w_rd_data | (w_rd_sel[k] ? w_val[k] : '0);
            w_rd_any  = w_rd_any | w_rd_sel[k];
        end
    end

    always_comb begin
        w_cmd            = '0;
        w_cmd.value      = i_item.value;
        w_cmd.position   = i_item.position;
        n_count          = r_count;
        n_result.status  = ST_MISS;
        n_result.data    = '0;
        if (w_accept) begin
            unique case (i_item.operation)
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_result.status = ST_FULL;
                    end else begin
                        w_cmd.push_front = 1'b1;
                        n_count          = r_count + ONE_CNT;
                        n_result.status  = ST_OK;
                    end
                end
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_result.status = ST_FULL;
                    end else begin
                        w_cmd.push_back = 1'b1;
                        n_count         = r_count + ONE_CNT;
                        n_result.status = ST_OK;
                    end
                end
                OP_READ_AT: begin
                    if (w_rd_any) begin
                        n_result.data   = w_rd_data;
                        n_result.status = ST_OK;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_count != '0) begin
                        w_cmd.pop_front = 1'b1;
                        n_result.data   = w_val[0];
                        n_count         = r_count - ONE_CNT;
                        n_result.status = ST_OK;
                    end
                end
                OP_REMOVE: begin
                    w_cmd.remove = 1'b1;
                    if (w_found[DEPTH]) begin
                        n_count         = r_count - ONE_CNT;
                        n_result.status = ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end
        n_result.length = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // fill level never passes the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("list count beyond depth");

    // every transfer yields exactly one strobe on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept))
        else $error("result strobe without transfer");

    // a full report only comes from a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_FULL) |-> (r_count == FULL_CNT))
        else $error("full status on a list with room");

    // a successful remove shrinks the list by one
    a_remove_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.operation == OP_REMOVE && w_found[DEPTH])
            |=> (r_count == $past(r_count) - ONE_CNT))
        else $error("remove did not shrink list");

endmodule

FILE: rtl/ols_cell.sv
// ----------------------------------------------------------------------------
// ols_cell
// One slot of the list. Holds a word, takes its left or right neighbor's word
// on a shift, matches the search value and flags itself for a positional read.
// ----------------------------------------------------------------------------
module ols_cell #(
    parameter int DEPTH = ols_pkg::DEF_DEPTH,
    parameter int IDX   = 0
) (
    input  logic                              i_clk,
    input  ols_pkg::t_cell_cmd                i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0]        i_count,
    input  logic signed [ols_pkg::DATA_W-1:0] i_left,
    input  logic signed [ols_pkg::DATA_W-1:0] i_right,
    input  logic                              i_found,
    output logic                              o_found,
    output logic                              o_rd_sel,
    output logic signed [ols_pkg::DATA_W-1:0] o_val
);
    import ols_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(IDX);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     w_used;
    logic                     w_hit;

    assign w_used   = (MY_IDX < i_count);
    assign w_hit    = w_used && (r_val == i_cmd.value);
    // first match closes the gap: it and everything after it shift left
    assign o_found  = i_found | w_hit;
    assign o_rd_sel = w_used && (MY_POS == CMP_W'(i_cmd.position));
    assign o_val    = r_val;

    always_comb begin
        n_val = r_val;
        priority if (i_cmd.push_front) begin
            n_val = (IDX == 0) ? i_cmd.value : i_left;
        end else if (i_cmd.push_back) begin
            if (MY_IDX == i_count) begin
                n_val = i_cmd.value;
            end
        end else if (i_cmd.pop_front) begin
            n_val = i_right;
        end else if (i_cmd.remove && o_found) begin
            n_val = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_list_store. A directed run covers the list
// edges and the error cases; random blocks then swing the list between empty
// and full. Every accepted command is applied to a local list model, and each
// result strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import ols_pkg::*;

    localparam int LIST_DEPTH = DEF_DEPTH;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_BLOCKS = 47;
    localparam int BLOCK_LEN = 32;
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    typedef struct {
        t_item it;
        int    gap;
        bit    wait_empty;
    } t_cmd_slot;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_valid;
    t_result o_result;

    t_cmd_slot cmd_q[$];
    t_result   want_q[$];

    // local copy of the list, head at index 0
    logic signed [DATA_W-1:0] list_mem[LIST_DEPTH];
    int list_len = 0;

    logic signed [DATA_W-1:0] val_pool[8];
    bit took = 1'b0;
    int err_cnt = 0;
    int xfer_cnt = 0;
    int cmd_total = 0;
    int idle_cycles = 0;

    ordered_list_store dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result apply_op(t_item it);
        t_result r;
        int hit;
        r.status = ST_MISS;
        r.data = '0;
        hit = -1;
        case (it.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (it.operation == OP_PUSH_FRONT) begin
                        for (int i = list_len; i > 0; i--)
                            list_mem[i] = list_mem[i-1];
                        list_mem[0] = it.value;
                    end else begin
                        list_mem[list_len] = it.value;
                    end
                    list_len++;
                    r.status = ST_OK;
                end
            end
            OP_READ_AT: begin
                if (int'(it.position) < list_len) begin
                    r.data = list_mem[it.position];
                    r.status = ST_OK;
                end
            end
            OP_POP_FRONT: begin
                if (list_len > 0) begin
                    r.data = list_mem[0];
                    for (int i = 0; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < list_len && hit < 0; i++)
                    if (list_mem[i] === it.value) hit = i;
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.length = LEN_W'(list_len);
        return r;
    endfunction

    task automatic queue_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                             logic [POS_W-1:0] pos, int gap, bit wait_empty);
        t_cmd_slot s;
        s.it.operation = op;
        s.it.value = val;
        s.it.position = pos;
        s.gap = gap;
        s.wait_empty = wait_empty;
        cmd_q.push_back(s);
        cmd_total++;
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // small pool so removes hit and duplicates show up
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0) return val_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        case (mix)
            MIX_FILL: begin
                if (r < 40) return OP_PUSH_FRONT;
                if (r < 80) return OP_PUSH_BACK;
                if (r < 90) return OP_READ_AT;
                if (r < 95) return OP_POP_FRONT;
                return OP_REMOVE;
            end
            MIX_DRAIN: begin
                if (r < 10) return OP_PUSH_FRONT;
                if (r < 18) return OP_PUSH_BACK;
                if (r < 33) return OP_READ_AT;
                if (r < 66) return OP_POP_FRONT;
                return OP_REMOVE;
            end
            default: begin
                if (r < 22) return OP_PUSH_FRONT;
                if (r < 42) return OP_PUSH_BACK;
                if (r < 62) return OP_READ_AT;
                if (r < 80) return OP_POP_FRONT;
                return OP_REMOVE;
            end
        endcase
    endfunction

    // driver: a command holds until transferred, then the next one follows its gap
    always @(negedge i_clk) begin
        bit present;
        present = 1'b0;
        if (!i_rst_n) begin
            present = 1'b0;
        end else if (start && !took) begin
            present = 1'b1;
        end else if (cmd_q.size() != 0) begin
            if (cmd_q[0].gap > 0) begin
                cmd_q[0].gap = cmd_q[0].gap - 1;
            end else if (!(cmd_q[0].wait_empty && want_q.size() != 0)) begin
                i_item <= cmd_q[0].it;
                cmd_q.pop_front();
                present = 1'b1;
            end
        end
        start <= present;
    end

    // monitor: check results, predict accepted commands, watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                err_cnt++;
                $display("%0t: result strobe unknown", $time);
            end else if (o_valid) begin
                if (want_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result status=%0d data=%0d length=%0d",
                             $time, o_result.status, o_result.data, o_result.length);
                end else begin
                    want = want_q.pop_front();
                    if (o_result.status !== want.status || o_result.data !== want.data ||
                        o_result.length !== want.length) begin
                        err_cnt++;
                        $display(
                            "%0t: expected st=%0d data=%0d len=%0d, got st=%0d data=%0d len=%0d",
                            $time, want.status, want.data, want.length,
                            o_result.status, o_result.data, o_result.length);
                    end
                end
            end
            if (start && !busy) begin
                want_q.push_back(apply_op(i_item));
                xfer_cnt++;
            end
            if (o_valid === 1'b1 || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
        took <= i_rst_n && start && !busy;
    end

    initial begin
        t_mix mix;
        bit quiet;
        val_pool[0] = 32'sd0;
        val_pool[1] = -32'sd1;
        val_pool[2] = 32'sh8000_0000;
        val_pool[3] = 32'sh7FFF_FFFF;
        val_pool[4] = 32'sd1;
        for (int i = 5; i < 8; i++) val_pool[i] = $urandom;

        // directed: extremes, every operation, each miss path
        queue_cmd(OP_PUSH_BACK, 32'sh7FFF_FFFF, '0, 0, 1'b0);
        queue_cmd(OP_PUSH_FRONT, 32'sh8000_0000, '0, 0, 1'b0);
        queue_cmd(OP_PUSH_BACK, -32'sd1, '0, 1, 1'b0);
        queue_cmd(OP_PUSH_BACK, 32'sd0, '1, 0, 1'b0);
        queue_cmd(OP_READ_AT, '0, 4'd0, 0, 1'b0);
        queue_cmd(OP_READ_AT, '0, 4'd3, 0, 1'b0);
        queue_cmd(OP_READ_AT, '1, 4'd15, 2, 1'b0);       // past the length
        queue_cmd(OP_REMOVE, -32'sd1, '0, 0, 1'b0);      // hit in the middle
        queue_cmd(OP_REMOVE, 32'sd12345, '0, 0, 1'b0);   // not found
        queue_cmd(OP_POP_FRONT, '0, '0, 0, 1'b0);
        queue_cmd(OP_POP_FRONT, '0, '0, 0, 1'b0);
        queue_cmd(OP_POP_FRONT, '0, '0, 0, 1'b0);
        queue_cmd(OP_POP_FRONT, '0, '0, 0, 1'b0);        // empty
        queue_cmd(OP_READ_AT, '0, 4'd0, 0, 1'b0);        // empty
        queue_cmd(OP_REMOVE, 32'sd0, '0, 0, 1'b0);       // empty
        for (int k = OP_RSVD_FIRST; k <= OP_RSVD_LAST; k++)
            queue_cmd(OP_W'(k), $urandom, POS_W'($urandom), 0, 1'b0);

        // random blocks; the first one fills the list past full
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            mix = (b == 0) ? MIX_FILL : t_mix'($urandom_range(0, 2));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_LEN; n++)
                queue_cmd(pick_op(mix), pick_value(), POS_W'($urandom),
                          pick_gap(quiet), (n == 0) && (b % 6 == 0));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (xfer_cnt != cmd_total || want_q.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0 && want_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
